[design/dbpc_pkg.sv]
// dbpc_pkg: widths, action codes, register indexes and the command and status
// structs shared by the dbscan point clustering controller, datapath and top level
// no dependencies
package dbpc_pkg;

  localparam int MAX_POINTS = 4096;
  localparam int ADDR_W     = 12;
  localparam int CNT_W      = 13;
  localparam int COORD_W    = 20;
  localparam int RAD_W      = 16;
  localparam int LABEL_W    = 13;
  localparam int SQ_W       = 32;
  localparam int SUM_W      = 34;
  localparam int CFG_IDX_W  = 1;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 32;

  localparam logic [LABEL_W-1:0] LABEL_MAX = 13'd8191;

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_RUN  = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS        = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_NEIGHBORS = 1'b1;

  typedef struct packed {
    logic do_load;
    logic do_read;
    logic read_out;
    logic run_init;
    logic clr_step;
    logic outer_rd;
    logic ref_latch;
    logic next_i;
    logic scan_start;
    logic scan_expand;
    logic seed_cluster;
    logic pop;
    logic p_rd;
    logic run_out;
  } dbpc_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic i_done;
    logic lab_nz;
    logic scan_busy;
    logic core;
    logic queue_empty;
    logic p_is_i;
    logic out_free;
  } dbpc_status_t;

endpackage

[design/dbpc_ctrl.sv]
// dbpc_ctrl: state machine that sequences load, read and the dbscan run
// depends on dbpc_pkg; drives commands into dbpc_datapath
module dbpc_ctrl import dbpc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [1:0]   action,
  input  dbpc_status_t status,
  output dbpc_cmd_t    cmd
);

  typedef enum logic [14:0] {
    S_IDLE       = 15'h0001,
    S_RD_WAIT    = 15'h0002,
    S_CLR        = 15'h0004,
    S_OUTER      = 15'h0008,
    S_OUT_CHK    = 15'h0010,
    S_CORE_GO    = 15'h0020,
    S_CORE_WAIT  = 15'h0040,
    S_POP        = 15'h0080,
    S_P_RD       = 15'h0100,
    S_REF        = 15'h0200,
    S_CORE2_GO   = 15'h0400,
    S_CORE2_WAIT = 15'h0800,
    S_EXP_GO     = 15'h1000,
    S_EXP_WAIT   = 15'h2000,
    S_FINISH     = 15'h4000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = status.out_free;
        if (s_tvalid && status.out_free) begin
          case (action)
            ACT_LOAD: cmd.do_load = 1'b1;
            ACT_READ: begin
              cmd.do_read = 1'b1;
              state_next  = S_RD_WAIT;
            end
            ACT_RUN: begin
              cmd.run_init = 1'b1;
              state_next   = S_CLR;
            end
            default: ;
          endcase
        end
      end
      S_RD_WAIT: begin
        cmd.read_out = 1'b1;
        state_next   = S_IDLE;
      end
      S_CLR: begin
        if (status.clr_done) begin
          state_next = S_OUTER;
        end else begin
          cmd.clr_step = 1'b1;
        end
      end
      S_OUTER: begin
        if (status.i_done) begin
          state_next = S_FINISH;
        end else begin
          cmd.outer_rd = 1'b1;
          state_next   = S_OUT_CHK;
        end
      end
      S_OUT_CHK: begin
        if (status.lab_nz) begin
          cmd.next_i = 1'b1;
          state_next = S_OUTER;
        end else begin
          cmd.ref_latch = 1'b1;
          state_next    = S_CORE_GO;
        end
      end
      S_CORE_GO: begin
        cmd.scan_start = 1'b1;
        state_next     = S_CORE_WAIT;
      end
      S_CORE_WAIT: begin
        if (!status.scan_busy) begin
          if (status.core) begin
            cmd.seed_cluster = 1'b1;
            state_next       = S_POP;
          end else begin
            cmd.next_i = 1'b1;
            state_next = S_OUTER;
          end
        end
      end
      S_POP: begin
        if (status.queue_empty) begin
          cmd.next_i = 1'b1;
          state_next = S_OUTER;
        end else begin
          cmd.pop    = 1'b1;
          state_next = S_P_RD;
        end
      end
      S_P_RD: begin
        cmd.p_rd   = 1'b1;
        state_next = S_REF;
      end
      S_REF: begin
        cmd.ref_latch = 1'b1;
        state_next    = status.p_is_i ? S_EXP_GO : S_CORE2_GO;
      end
      S_CORE2_GO: begin
        cmd.scan_start = 1'b1;
        state_next     = S_CORE2_WAIT;
      end
      S_CORE2_WAIT: begin
        if (!status.scan_busy) begin
          state_next = status.core ? S_EXP_GO : S_POP;
        end
      end
      S_EXP_GO: begin
        cmd.scan_start  = 1'b1;
        cmd.scan_expand = 1'b1;
        state_next      = S_EXP_WAIT;
      end
      S_EXP_WAIT: begin
        if (!status.scan_busy) begin
          state_next = S_POP;
        end
      end
      S_FINISH: begin
        cmd.run_out = 1'b1;
        state_next  = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[design/dbpc_datapath.sv]
// dbpc_datapath: point, label and seed queue memories, config registers,
// pipelined neighbor test with scan counter, and the result register
// depends on dbpc_pkg; commanded by dbpc_ctrl
module dbpc_datapath import dbpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [RAD_W-1:0]      cfg_data,
  input  logic [COORD_W-1:0]    in_x,
  input  logic [COORD_W-1:0]    in_y,
  input  logic [COORD_W-1:0]    in_z,
  input  logic                  in_first,
  input  logic [ADDR_W-1:0]     in_index,
  input  dbpc_cmd_t             cmd,
  output dbpc_status_t          status,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data
);

  localparam logic [COORD_W-1:0] SIGN = COORD_W'(1) << (COORD_W - 1);

  logic [RAD_W-1:0]   radius;
  logic [CNT_W-1:0]   min_nb;
  logic [SQ_W-1:0]    rsq;
  logic [CNT_W-1:0]   count, clusters, i, k, head, tail, ncnt;
  logic [ADDR_W-1:0]  p, j;
  logic               scan_act, scan_exp;

  logic [3*COORD_W-1:0] coord_mem [MAX_POINTS];
  logic [LABEL_W-1:0]   label_mem [MAX_POINTS];
  logic [ADDR_W-1:0]    seed_mem  [MAX_POINTS];
  logic [3*COORD_W-1:0] coord_rd;
  logic [LABEL_W-1:0]   label_rd;
  logic [ADDR_W-1:0]    seed_rd;

  logic [COORD_W-1:0] rx, ry, rz;

  logic               v1, v2, v3, v4;
  logic [ADDR_W-1:0]  j1, j2, j3, j4;
  logic [RAD_W-1:0]   dx2, dy2, dz2;
  logic               far2, far3, lnz2, lnz3, lnz4, near4;
  logic [SQ_W-1:0]    sx3, sy3, sz3;

  logic [CNT_W-1:0]   ld_count;
  logic               ld_full;
  logic [LABEL_W-1:0] lab_new;
  logic               wb;
  logic               rd_ok;

  logic [ADDR_W-1:0]  coord_raddr, label_raddr, label_waddr, seed_waddr;
  logic [LABEL_W-1:0] label_wdata;
  logic [ADDR_W-1:0]  seed_wdata;
  logic               label_we, seed_we, coord_we;

  logic [COORD_W-1:0] dx, dy, dz;
  logic [SUM_W-1:0]   dsum;

  logic [LABEL_W-1:0] out_label;
  logic [CNT_W-1:0]   out_cnt;
  logic               out_ovf;

  function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                  input logic [COORD_W-1:0] b);
    abs_diff = (a >= b) ? a - b : b - a;
  endfunction

  assign ld_count = in_first ? '0 : count;
  assign ld_full  = (ld_count == CNT_W'(MAX_POINTS));
  assign coord_we = cmd.do_load && !ld_full;
  assign lab_new  = (clusters == LABEL_MAX) ? clusters : clusters + 1'b1;
  assign wb       = v4 && scan_exp && near4 && !lnz4;

  always_comb begin
    if (scan_act) begin
      coord_raddr = j;
    end else if (cmd.p_rd) begin
      coord_raddr = seed_rd;
    end else begin
      coord_raddr = i[ADDR_W-1:0];
    end
    if (scan_act) begin
      label_raddr = j;
    end else if (cmd.do_read) begin
      label_raddr = in_index;
    end else begin
      label_raddr = i[ADDR_W-1:0];
    end
  end

  always_comb begin
    label_we    = 1'b0;
    label_waddr = k[ADDR_W-1:0];
    label_wdata = '0;
    seed_we     = 1'b0;
    seed_waddr  = tail[ADDR_W-1:0];
    seed_wdata  = j4;
    if (cmd.clr_step) begin
      label_we = 1'b1;
    end else if (coord_we) begin
      label_we    = 1'b1;
      label_waddr = ld_count[ADDR_W-1:0];
    end else if (cmd.seed_cluster) begin
      label_we    = 1'b1;
      label_waddr = i[ADDR_W-1:0];
      label_wdata = lab_new;
      seed_we     = 1'b1;
      seed_waddr  = '0;
      seed_wdata  = i[ADDR_W-1:0];
    end else if (wb) begin
      label_we    = 1'b1;
      label_waddr = j4;
      label_wdata = clusters;
      seed_we     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (coord_we) begin
      coord_mem[ld_count[ADDR_W-1:0]] <= {in_z ^ SIGN, in_y ^ SIGN, in_x ^ SIGN};
    end
    coord_rd <= coord_mem[coord_raddr];
  end

  always_ff @(posedge clk) begin
    if (label_we) begin
      label_mem[label_waddr] <= label_wdata;
    end
    label_rd <= label_mem[label_raddr];
  end

  always_ff @(posedge clk) begin
    if (seed_we) begin
      seed_mem[seed_waddr] <= seed_wdata;
    end
    seed_rd <= seed_mem[head[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RAD_W'(286);
      min_nb <= CNT_W'(3);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RADIUS:        radius <= cfg_data;
        REG_MIN_NEIGHBORS: min_nb <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rsq <= SQ_W'(radius) * SQ_W'(radius);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      clusters <= '0;
    end else begin
      if (cmd.do_load) begin
        count <= ld_full ? ld_count : ld_count + 1'b1;
      end
      if (cmd.run_init) begin
        clusters <= '0;
      end else if (cmd.seed_cluster) begin
        clusters <= lab_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.run_init) begin
      i <= '0;
      k <= '0;
    end else begin
      if (cmd.next_i) i <= i + 1'b1;
      if (cmd.clr_step) k <= k + 1'b1;
    end
    if (cmd.seed_cluster) begin
      head <= '0;
      tail <= CNT_W'(1);
    end else begin
      if (cmd.pop) head <= head + 1'b1;
      if (wb) tail <= tail + 1'b1;
    end
    if (cmd.p_rd) p <= seed_rd;
    if (cmd.do_read) rd_ok <= ({1'b0, in_index} < count);
    if (cmd.ref_latch) begin
      rx <= coord_rd[COORD_W-1:0];
      ry <= coord_rd[2*COORD_W-1:COORD_W];
      rz <= coord_rd[3*COORD_W-1:2*COORD_W];
    end
  end

  // scan counter and pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_act <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (cmd.scan_start) begin
        scan_act <= 1'b1;
      end else if (scan_act && ({1'b0, j} == count - 1'b1)) begin
        scan_act <= 1'b0;
      end
      v1 <= scan_act;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      j        <= '0;
      scan_exp <= cmd.scan_expand;
      ncnt     <= '0;
    end else begin
      if (scan_act) j <= j + 1'b1;
      if (v4 && near4 && !scan_exp) ncnt <= ncnt + 1'b1;
    end
  end

  // neighbor test: abs diffs, squares, sum and compare
  assign dx   = abs_diff(rx, coord_rd[COORD_W-1:0]);
  assign dy   = abs_diff(ry, coord_rd[2*COORD_W-1:COORD_W]);
  assign dz   = abs_diff(rz, coord_rd[3*COORD_W-1:2*COORD_W]);
  assign dsum = SUM_W'(sx3) + SUM_W'(sy3) + SUM_W'(sz3);

  always_ff @(posedge clk) begin
    j1    <= j;
    j2    <= j1;
    dx2   <= dx[RAD_W-1:0];
    dy2   <= dy[RAD_W-1:0];
    dz2   <= dz[RAD_W-1:0];
    far2  <= (dx > COORD_W'(radius)) || (dy > COORD_W'(radius)) ||
             (dz > COORD_W'(radius));
    lnz2  <= (label_rd != '0);
    j3    <= j2;
    sx3   <= SQ_W'(dx2) * SQ_W'(dx2);
    sy3   <= SQ_W'(dy2) * SQ_W'(dy2);
    sz3   <= SQ_W'(dz2) * SQ_W'(dz2);
    far3  <= far2;
    lnz3  <= lnz2;
    j4    <= j3;
    lnz4  <= lnz3;
    near4 <= !far3 && (dsum <= SUM_W'(rsq));
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.do_load || cmd.read_out || cmd.run_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.do_load || cmd.read_out || cmd.run_out) begin
      out_cnt   <= clusters;
      out_ovf   <= cmd.do_load && ld_full;
      out_label <= (cmd.read_out && rd_ok) ? label_rd : '0;
    end
  end

  assign out_data = {4'b0, out_ovf, (out_cnt != '0), out_cnt, out_label};

  assign status.clr_done    = (k == count);
  assign status.i_done      = (i == count);
  assign status.lab_nz      = (label_rd != '0);
  assign status.scan_busy   = scan_act || v1 || v2 || v3 || v4;
  assign status.core        = (ncnt >= min_nb);
  assign status.queue_empty = (head == tail);
  assign status.p_is_i      = ({1'b0, p} == i);
  assign status.out_free    = !out_valid || out_ready;

endmodule

[design/dbscan_point_clustering_core.sv]
// dbscan point clustering core: load sustains 1 per cycle while the result register is free
// run: labels are cleared over the loaded points, then per point a scan through the neighbor
// pipeline for the core test and another for each cluster expansion
// reset: synchronous, clears counts and control, radius 286, min_neighbors 3;
// label memory is swept to zero over the loaded points at the start of each run
module dbscan_point_clustering_core import dbpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // coord_x, coord_y, coord_z, first_point, point_index
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // action
  input  logic [1:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // cluster_label, cluster_count, found_any, overflow
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [RAD_W-1:0]      cfg_data
);

  dbpc_cmd_t    cmd;
  dbpc_status_t status;

  dbpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .action   (s_tuser),
    .status   (status),
    .cmd      (cmd)
  );

  dbpc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_x      (s_tdata[COORD_W-1:0]),
    .in_y      (s_tdata[2*COORD_W-1:COORD_W]),
    .in_z      (s_tdata[3*COORD_W-1:2*COORD_W]),
    .in_first  (s_tdata[3*COORD_W]),
    .in_index  (s_tdata[3*COORD_W+ADDR_W:3*COORD_W+1]),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

  a_scan_starts: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_start |=> status.scan_busy)
    else $error("scan did not start");

  a_run_out_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.run_out |-> !status.scan_busy)
    else $error("run result while scan busy");

  a_seed_queue: assert property (@(posedge clk) disable iff (rst)
    cmd.seed_cluster |=> !status.queue_empty)
    else $error("seed queue empty after cluster seed");

endmodule
